/* rtl/dlqt_pkg.sv */
package dlqt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int QUEUE_DEPTH   = 8;
    localparam int THREAD_BITS   = 8;

    localparam int ADDR_W = 48;
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ROW_W  = QUEUE_DEPTH * THREAD_BITS;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POLL    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_QUEUED     = 3'd0,
        STS_GRANTED    = 3'd1,
        STS_WAITING    = 3'd2,
        STS_RELEASED   = 3'd3,
        STS_TABLE_FULL = 3'd4,
        STS_QUEUE_FULL = 3'd5
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

/* rtl/dlqt_ram.sv */
module dlqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dlqt_ctrl.sv */
module dlqt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dlqt_pkg::t_dp_sts  i_sts,
    output dlqt_pkg::t_dp_cmd  o_cmd
);

    dlqt_pkg::t_state r_state;
    dlqt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlqt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        o_stall      = 1'b1;
        case (r_state)
            dlqt_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dlqt_pkg::ST_EXEC;
                end
            end
            dlqt_pkg::ST_EXEC: begin
                if (!i_sts.out_full) begin
                    o_cmd.commit = 1'b1;
                    n_state      = dlqt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dlqt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dlqt_dp.sv */
module dlqt_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dlqt_pkg::t_dp_cmd                   i_cmd,
    output dlqt_pkg::t_dp_sts                   o_sts,
    input  logic [1:0]                          i_operation,
    input  logic [dlqt_pkg::ADDR_W-1:0]         i_lock_addr,
    input  logic [7:0]                          i_thread_id,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [2:0]                          o_status,
    output logic                                o_holder_valid,
    output logic [7:0]                          o_holder_thread,
    output logic [3:0]                          o_queue_length
);

    localparam int TE = dlqt_pkg::TABLE_ENTRIES;
    localparam int QD = dlqt_pkg::QUEUE_DEPTH;
    localparam int TB = dlqt_pkg::THREAD_BITS;

    logic                          r_used   [TE];
    logic [dlqt_pkg::ADDR_W-1:0]   r_addr   [TE];
    logic                          r_free   [TE];
    logic [TB-1:0]                 r_holder [TE];
    logic [dlqt_pkg::CNT_W-1:0]    r_count  [TE];

    dlqt_pkg::t_op                 r_op;
    logic [dlqt_pkg::ADDR_W-1:0]   r_key;
    logic [TB-1:0]                 r_tid;
    logic                          r_hit;
    logic                          r_avail;
    logic [dlqt_pkg::IDX_W-1:0]    r_idx;

    logic                          r_out_valid;
    logic [2:0]                    r_status;
    logic                          r_holder_valid;
    logic [7:0]                    r_holder_thread;
    logic [3:0]                    r_queue_length;

    logic                          l_hit;
    logic                          l_avail;
    logic [dlqt_pkg::IDX_W-1:0]    l_hit_idx;
    logic [dlqt_pkg::IDX_W-1:0]    l_free_idx;
    logic [dlqt_pkg::IDX_W-1:0]    l_idx;

    logic [dlqt_pkg::ROW_W-1:0]    w_row;
    logic [TB-1:0]                 w_q     [QD];
    logic                          w_le    [QD];
    logic [dlqt_pkg::ROW_W-1:0]    w_ins_row;
    logic [dlqt_pkg::ROW_W-1:0]    w_pop_row;
    logic [dlqt_pkg::CNT_W-1:0]    w_cnt;
    logic                          w_row_we;

    logic                          x_write_row;
    logic [dlqt_pkg::ROW_W-1:0]    x_row;
    logic                          x_alloc;
    logic                          x_reclaim;
    logic                          x_exists;
    logic                          x_upd;
    logic                          x_free;
    logic [TB-1:0]                 x_holder;
    logic [dlqt_pkg::CNT_W-1:0]    x_count;
    dlqt_pkg::t_status             x_status;

    always_comb begin
        l_hit      = 1'b0;
        l_avail    = 1'b0;
        l_hit_idx  = '0;
        l_free_idx = '0;
        for (int i = TE - 1; i >= 0; i--) begin
            if (r_used[i] && (r_addr[i] == i_lock_addr)) begin
                l_hit     = 1'b1;
                l_hit_idx = dlqt_pkg::IDX_W'(i);
            end
            if (!r_used[i]) begin
                l_avail    = 1'b1;
                l_free_idx = dlqt_pkg::IDX_W'(i);
            end
        end
        l_idx = l_hit ? l_hit_idx : l_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= dlqt_pkg::t_op'(i_operation);
            r_key   <= i_lock_addr;
            r_tid   <= TB'(i_thread_id);
            r_hit   <= l_hit;
            r_avail <= l_avail;
            r_idx   <= l_idx;
        end
    end

    assign w_row_we = i_cmd.commit && x_write_row;

    dlqt_ram #(
        .WIDTH (dlqt_pkg::ROW_W),
        .DEPTH (TE)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (r_idx),
        .i_wdata (x_row),
        .i_re    (i_cmd.load),
        .i_raddr (l_idx),
        .o_rdata (w_row)
    );

    // The queue is sorted, so the lanes at or below the new id form a prefix.
    always_comb begin
        w_cnt = r_hit ? r_count[r_idx] : '0;
        for (int k = 0; k < QD; k++) begin
            w_q[k]  = w_row[k*TB +: TB];
            w_le[k] = (dlqt_pkg::CNT_W'(k) < w_cnt) && (w_q[k] <= r_tid);
        end
        for (int k = 0; k < QD; k++) begin
            if (w_le[k]) begin
                w_ins_row[k*TB +: TB] = w_q[k];
            end else if (k == 0) begin
                w_ins_row[k*TB +: TB] = r_tid;
            end else if (w_le[(k > 0) ? k - 1 : 0]) begin
                w_ins_row[k*TB +: TB] = r_tid;
            end else begin
                w_ins_row[k*TB +: TB] = w_q[(k > 0) ? k - 1 : 0];
            end
            w_pop_row[k*TB +: TB] = w_q[(k < QD - 1) ? k + 1 : k];
        end
    end

    always_comb begin
        x_write_row = 1'b0;
        x_row       = w_ins_row;
        x_alloc     = 1'b0;
        x_reclaim   = 1'b0;
        x_upd       = 1'b0;
        x_exists    = r_hit;
        x_free      = r_hit ? r_free[r_idx] : 1'b1;
        x_holder    = r_hit ? r_holder[r_idx] : '0;
        x_count     = w_cnt;
        x_status    = dlqt_pkg::STS_WAITING;
        case (r_op)
            dlqt_pkg::OP_ENQUEUE: begin
                if (r_hit && (w_cnt >= dlqt_pkg::CNT_W'(QD))) begin
                    x_status = dlqt_pkg::STS_QUEUE_FULL;
                end else if (!r_hit && !r_avail) begin
                    x_status = dlqt_pkg::STS_TABLE_FULL;
                end else begin
                    x_status    = dlqt_pkg::STS_QUEUED;
                    x_write_row = 1'b1;
                    x_upd       = 1'b1;
                    x_alloc     = !r_hit;
                    x_exists    = 1'b1;
                    x_count     = w_cnt + dlqt_pkg::CNT_W'(1);
                end
            end
            dlqt_pkg::OP_POLL: begin
                if (r_hit && x_free && (w_cnt != '0) && (w_q[0] == r_tid)) begin
                    x_status    = dlqt_pkg::STS_GRANTED;
                    x_write_row = 1'b1;
                    x_row       = w_pop_row;
                    x_upd       = 1'b1;
                    x_free      = 1'b0;
                    x_holder    = r_tid;
                    x_count     = w_cnt - dlqt_pkg::CNT_W'(1);
                end
            end
            dlqt_pkg::OP_RELEASE: begin
                x_status = dlqt_pkg::STS_RELEASED;
                if (r_hit) begin
                    x_upd    = 1'b1;
                    x_free   = 1'b1;
                    x_holder = '0;
                    if (w_cnt == '0) begin
                        x_reclaim = 1'b1;
                        x_exists  = 1'b0;
                    end
                end
            end
            default: begin
                x_status = dlqt_pkg::STS_WAITING;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TE; i++) begin
                r_used[i]   <= 1'b0;
                r_free[i]   <= 1'b1;
                r_holder[i] <= '0;
                r_count[i]  <= '0;
            end
        end else if (i_cmd.commit && x_upd) begin
            r_free[r_idx]   <= x_free;
            r_holder[r_idx] <= x_holder;
            r_count[r_idx]  <= x_count;
            if (x_alloc) begin
                r_used[r_idx] <= 1'b1;
            end else if (x_reclaim) begin
                r_used[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && x_alloc) begin
            r_addr[r_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status        <= x_status;
            r_holder_valid  <= x_exists && !x_free;
            r_holder_thread <= (x_exists && !x_free) ? 8'(x_holder) : 8'd0;
            r_queue_length  <= x_exists ? 4'(x_count) : 4'd0;
        end
    end

    assign o_sts.out_full   = r_out_valid && i_stall;
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_holder_valid   = r_holder_valid;
    assign o_holder_thread  = r_holder_thread;
    assign o_queue_length   = r_queue_length;

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("result register not loaded after commit");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && x_upd) |-> (x_count <= dlqt_pkg::CNT_W'(QD)))
        else $error("queue count beyond queue depth");

    a_no_idle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used[r_idx] && (r_count[r_idx] == '0)) |-> !r_free[r_idx])
        else $error("used entry is free with an empty queue");

    a_no_commit_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !(r_out_valid && i_stall))
        else $error("commit while a result is still waiting");

endmodule

/* rtl/deterministic_lock_queue_table.sv */
// Lock queue table: each item passes through an idle (transfer) state and an execute state. In the
// transfer cycle the lock address is compared against all table entries at once and the
// entry's queue row is read from the queue RAM; in the execute state the sorted insert or
// head pop is done on that row, the row is written back and the result register is loaded.
// The input side stalls during the execute state. A new transfer is still taken while a
// finished result waits, but its execute state lasts until that result is taken, so the
// input stalls from then on. No clearing pass is needed after reset.
module deterministic_lock_queue_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_operation,
    input  logic [dlqt_pkg::ADDR_W-1:0]  i_lock_addr,
    input  logic [7:0]                   i_thread_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [2:0]                   o_status,
    output logic                         o_holder_valid,
    output logic [7:0]                   o_holder_thread,
    output logic [3:0]                   o_queue_length
);

    dlqt_pkg::t_dp_cmd w_cmd;
    dlqt_pkg::t_dp_sts w_sts;

    dlqt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dlqt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_operation     (i_operation),
        .i_lock_addr     (i_lock_addr),
        .i_thread_id     (i_thread_id),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_holder_valid  (o_holder_valid),
        .o_holder_thread (o_holder_thread),
        .o_queue_length  (o_queue_length)
    );

endmodule

/* tb/deterministic_lock_queue_table_tb.sv */
module deterministic_lock_queue_table_tb;

    localparam int RANDOM_ITEMS = 1150;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_START   = 1200;
    localparam int HOLD_CYCLES  = 300;
    localparam int CALM_START   = 2500;
    localparam int CALM_END     = 3500;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TE           = dlqt_pkg::TABLE_ENTRIES;
    localparam int QD           = dlqt_pkg::QUEUE_DEPTH;
    localparam int AW           = dlqt_pkg::ADDR_W;
    localparam logic [AW-1:0] ADDR_MAX = '1;

    typedef struct packed {
        dlqt_pkg::t_op     op;
        logic [AW-1:0]     addr;
        logic [7:0]        tid;
    } t_lock_req;

    typedef struct packed {
        dlqt_pkg::t_status status;
        logic              holder_valid;
        logic [7:0]        holder_thread;
        logic [3:0]        queue_length;
    } t_lock_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_operation = dlqt_pkg::OP_NONE;
    logic [AW-1:0]     i_lock_addr = '0;
    logic [7:0]        i_thread_id = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [2:0]        o_status;
    logic              o_holder_valid;
    logic [7:0]        o_holder_thread;
    logic [3:0]        o_queue_length;

    // Shadow of the lock table.
    logic              ent_used    [TE];
    logic [AW-1:0]     ent_addr    [TE];
    logic              ent_free    [TE];
    logic [7:0]        ent_holder  [TE];
    int                ent_count   [TE];
    logic [7:0]        ent_waiters [TE][QD];

    t_lock_req         pending_q[$];
    t_lock_result      expected_q[$];
    logic [AW-1:0]     addr_pool[POOL_SIZE];
    int                cycle_count = 0;
    int                hold_left = 0;
    int                mismatches = 0;

    deterministic_lock_queue_table dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic void clear_lock_table();
        for (int i = 0; i < TE; i++) begin
            ent_used[i]   = 1'b0;
            ent_addr[i]   = '0;
            ent_free[i]   = 1'b1;
            ent_holder[i] = '0;
            ent_count[i]  = 0;
        end
    endfunction

    function automatic int find_lock(logic [AW-1:0] addr);
        for (int i = 0; i < TE; i++)
            if (ent_used[i] && ent_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic int find_unused_entry();
        for (int i = 0; i < TE; i++)
            if (!ent_used[i])
                return i;
        return -1;
    endfunction

    function automatic t_lock_result apply_lock_op(t_lock_req req);
        t_lock_result res;
        int           e;
        int           pos;
        e = find_lock(req.addr);
        res.status = dlqt_pkg::STS_WAITING;
        case (req.op)
            dlqt_pkg::OP_ENQUEUE: begin
                if (e < 0) begin
                    e = find_unused_entry();
                    if (e >= 0) begin
                        ent_used[e]   = 1'b1;
                        ent_addr[e]   = req.addr;
                        ent_free[e]   = 1'b1;
                        ent_holder[e] = '0;
                        ent_count[e]  = 0;
                    end
                end
                if (e < 0) begin
                    res.status = dlqt_pkg::STS_TABLE_FULL;
                end else if (ent_count[e] >= QD) begin
                    res.status = dlqt_pkg::STS_QUEUE_FULL;
                end else begin
                    pos = ent_count[e];
                    while (pos > 0 && ent_waiters[e][pos-1] > req.tid) begin
                        ent_waiters[e][pos] = ent_waiters[e][pos-1];
                        pos--;
                    end
                    ent_waiters[e][pos] = req.tid;
                    ent_count[e]++;
                    res.status = dlqt_pkg::STS_QUEUED;
                end
            end
            dlqt_pkg::OP_POLL: begin
                if (e >= 0 && ent_free[e] && ent_count[e] > 0 &&
                    ent_waiters[e][0] == req.tid) begin
                    for (int k = 1; k < ent_count[e]; k++)
                        ent_waiters[e][k-1] = ent_waiters[e][k];
                    ent_count[e]--;
                    ent_holder[e] = req.tid;
                    ent_free[e]   = 1'b0;
                    res.status    = dlqt_pkg::STS_GRANTED;
                end
            end
            dlqt_pkg::OP_RELEASE: begin
                res.status = dlqt_pkg::STS_RELEASED;
                if (e >= 0) begin
                    ent_free[e]   = 1'b1;
                    ent_holder[e] = '0;
                    if (ent_count[e] == 0) begin
                        ent_used[e] = 1'b0;
                        e = -1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (e >= 0) begin
            res.holder_valid  = !ent_free[e];
            res.holder_thread = ent_free[e] ? 8'd0 : ent_holder[e];
            res.queue_length  = 4'(ent_count[e]);
        end else begin
            res.holder_valid  = 1'b0;
            res.holder_thread = '0;
            res.queue_length  = '0;
        end
        return res;
    endfunction

    // Stimulus is built against the shadow table so that polls can name the real head.
    function automatic void add_req(dlqt_pkg::t_op op, logic [AW-1:0] addr, logic [7:0] tid);
        t_lock_req    req;
        t_lock_result ignored;
        req = '{op: op, addr: addr, tid: tid};
        pending_q = {pending_q, req};
        ignored = apply_lock_op(req);
    endfunction

    function automatic logic [AW-1:0] rand_addr();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[AW-1:0];
    endfunction

    function automatic logic [7:0] rand_tid();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(15));
        return 8'($urandom_range(255));
    endfunction

    // Picks a used entry: any, a held one, or one whose head may be granted.
    function automatic int pick_entry(int want);
        int hits[$];
        for (int i = 0; i < TE; i++) begin
            if (ent_used[i] && (want == 0 || (want == 1 && !ent_free[i]) ||
                (want == 2 && ent_free[i] && ent_count[i] > 0)))
                hits = {hits, i};
        end
        if (hits.size() == 0)
            return -1;
        return hits[$urandom_range(hits.size() - 1)];
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (cycle_count == HOLD_START)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge i_clk) begin : drive
        bit        took;
        bit        calm;
        t_lock_req req;
        if (i_rst_n) begin
            took = 1'b0;
            calm = cycle_count >= CALM_START && cycle_count < CALM_END;
            if (i_valid && !o_stall) begin
                req = '{op: dlqt_pkg::t_op'(i_operation), addr: i_lock_addr,
                        tid: i_thread_id};
                expected_q = {expected_q, apply_lock_op(req)};
                took = 1'b1;
            end
            if (!i_valid || took) begin
                if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 15)) begin
                    req = pending_q.pop_front();
                    i_valid     <= 1'b1;
                    i_operation <= req.op;
                    i_lock_addr <= req.addr;
                    i_thread_id <= req.tid;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch
        bit           calm;
        t_lock_result want;
        if (i_rst_n) begin
            calm = cycle_count >= CALM_START && cycle_count < CALM_END;
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: no transfer expected, actual status %0d", $time, o_status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("holder_valid", want.holder_valid, o_holder_valid);
                    check_field("holder_thread", want.holder_thread, o_holder_thread);
                    check_field("queue_length", want.queue_length, o_queue_length);
                end
            end
            i_stall <= hold_left > 0 || (!calm && $urandom_range(99) < 15);
        end
    end

    initial begin : stimulus
        logic [AW-1:0] addr;
        int            r;
        int            e;
        bit            filling;
        clear_lock_table();
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_MAX;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = rand_addr();

        // Grant on a fresh lock, then reclaim, then the unknown-lock cases.
        add_req(dlqt_pkg::OP_ENQUEUE, '0, 8'd0);
        add_req(dlqt_pkg::OP_POLL, '0, 8'd0);
        add_req(dlqt_pkg::OP_POLL, '0, 8'd9);
        add_req(dlqt_pkg::OP_RELEASE, '0, 8'd0);
        add_req(dlqt_pkg::OP_RELEASE, '0, 8'd0);
        add_req(dlqt_pkg::OP_POLL, '0, 8'd0);
        // Sorted insert with a duplicate, a poll from behind the head, a poll on a held lock.
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd255);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd3);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd3);
        add_req(dlqt_pkg::OP_POLL, ADDR_MAX, 8'd255);
        add_req(dlqt_pkg::OP_POLL, ADDR_MAX, 8'd3);
        add_req(dlqt_pkg::OP_POLL, ADDR_MAX, 8'd3);
        add_req(dlqt_pkg::OP_NONE, ADDR_MAX, 8'd0);
        add_req(dlqt_pkg::OP_RELEASE, ADDR_MAX, 8'd0);
        add_req(dlqt_pkg::OP_RELEASE, ADDR_MAX, 8'd0);
        // Fill the queue to its depth and push once more.
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd128);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd64);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd1);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd170);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd85);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd254);
        add_req(dlqt_pkg::OP_ENQUEUE, ADDR_MAX, 8'd7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // A burst of new locks overflows the table now and then.
            if (n % 300 == 150)
                for (int k = 0; k <= TE; k++)
                    add_req(dlqt_pkg::OP_ENQUEUE, rand_addr(), rand_tid());
            filling = ((n / 100) % 2) == 0;
            r = $urandom_range(99);
            if (r < (filling ? 50 : 20)) begin
                e = pick_entry(0);
                addr = (e >= 0 && $urandom_range(3) != 0) ? ent_addr[e]
                                                          : addr_pool[$urandom_range(POOL_SIZE-1)];
                add_req(dlqt_pkg::OP_ENQUEUE, addr, rand_tid());
            end else if (r < (filling ? 80 : 70)) begin
                e = pick_entry(2);
                if (e >= 0 && $urandom_range(4) != 0) begin
                    add_req(dlqt_pkg::OP_POLL, ent_addr[e], ent_waiters[e][0]);
                end else begin
                    e = pick_entry(0);
                    addr = (e >= 0) ? ent_addr[e] : addr_pool[$urandom_range(POOL_SIZE-1)];
                    add_req(dlqt_pkg::OP_POLL, addr, rand_tid());
                end
            end else if (r < 94) begin
                e = pick_entry(1);
                if (e < 0 || $urandom_range(5) == 0)
                    e = pick_entry(0);
                addr = (e >= 0) ? ent_addr[e] : addr_pool[$urandom_range(POOL_SIZE-1)];
                add_req(dlqt_pkg::OP_RELEASE, addr, rand_tid());
            end else begin
                add_req($urandom_range(1) ? dlqt_pkg::OP_NONE
                                          : dlqt_pkg::t_op'($urandom_range(3)),
                        ($urandom_range(1) ? rand_addr() : addr_pool[$urandom_range(POOL_SIZE-1)]),
                        8'($urandom_range(255)));
            end
        end
        clear_lock_table();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_q.size() != 0 || i_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
